// File: hdl/pfc_pkg.sv
// Package: shared types and constants of the Playfair digraph cipher.
package pfc_pkg;

    localparam int LetterW = 5;
    localparam int CoordW  = 3;
    localparam int IndexW  = 5;

    localparam logic [LetterW-1:0] LETTER_A = 5'd0;
    localparam logic [LetterW-1:0] LETTER_I = 5'd8;
    localparam logic [LetterW-1:0] LETTER_J = 5'd9;
    localparam logic [LetterW-1:0] LETTER_Z = 5'd25;

    localparam int Side  = 5;
    localparam int Cells = Side * Side;
    localparam int Alpha = 26;

    localparam logic [CoordW-1:0] COORD_LAST = CoordW'(Side - 1);
    localparam logic [IndexW-1:0] CELLS_FULL = IndexW'(Cells);

    typedef enum logic [1:0] {
        REQ_KEY     = 2'd0,
        REQ_FINISH  = 2'd1,
        REQ_ENCRYPT = 2'd2,
        REQ_DECRYPT = 2'd3
    } t_req;

    typedef struct packed {
        logic capture;
        logic place_key;
        logic fill_clear;
        logic fill_step;
        logic pos_read;
        logic cell_read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic square_ready;
        logic fill_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: hdl/playfair_digraph_cipher.sv
// Top level: Playfair 5x5 digraph cipher with streamed key setup.
// One request at a time. A key letter goes through the placement logic,
// a finish request steps it through the alphabet, one letter per cycle,
// and an encipher or decipher pair goes from acceptance to result through
// the position memory read, the square memory read, then the output register.
// A pair sent before the square is finished skips both reads and returns
// status 1 and zero letters. The output register lets the next request be
// accepted while a result still waits downstream. Letter codes above Z are
// read as Z and J is read as I. Key and finish requests give no result.
module playfair_digraph_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_letter_a,
    input  logic [4:0] i_letter_b,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_out_a,
    output logic [4:0] o_out_b,
    output logic       o_status
);

    pfc_pkg::t_dp_cmd    dp_cmd;
    pfc_pkg::t_dp_status dp_status;

    // sequencer: decodes the accepted request and steps the datapath
    pfc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_req_type   (i_req_type),
        .o_in_stall   (o_in_stall),
        .i_status_bus (dp_status),
        .o_cmd        (dp_cmd)
    );

    // key square, position table and result register
    pfc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status_bus (dp_status),
        .i_req_type   (i_req_type),
        .i_letter_a   (i_letter_a),
        .i_letter_b   (i_letter_b),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_a      (o_out_a),
        .o_out_b      (o_out_b),
        .o_status     (o_status)
    );

`ifndef NO_ASSERTIONS
    // a not-finished result carries zero letters
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_out_a == '0 && o_out_b == '0))
        else $error("not-finished result with nonzero letters");

    // J never sits in the square, so it never comes out of a lookup
    a_no_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_status) |->
        (o_out_a != pfc_pkg::LETTER_J && o_out_b != pfc_pkg::LETTER_J))
        else $error("J in cipher result");

    // an accepted pair request keeps the block busy in the cycle after
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_req_type != pfc_pkg::REQ_FINISH
         && i_req_type != pfc_pkg::REQ_KEY) |=> o_in_stall)
        else $error("pair request not held busy");
`endif

endmodule

// File: hdl/pfc_datapath.sv
// Datapath: key square stores, placement counters, pair lookup and output register.
module pfc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfc_pkg::t_dp_cmd          i_cmd,
    output pfc_pkg::t_dp_status       o_status_bus,
    input  logic [1:0]                i_req_type,
    input  logic [pfc_pkg::LetterW-1:0] i_letter_a,
    input  logic [pfc_pkg::LetterW-1:0] i_letter_b,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic [pfc_pkg::LetterW-1:0] o_out_a,
    output logic [pfc_pkg::LetterW-1:0] o_out_b,
    output logic                      o_status
);

    localparam int LW = pfc_pkg::LetterW;
    localparam int CW = pfc_pkg::CoordW;
    localparam int IW = pfc_pkg::IndexW;

    // request registers
    logic [1:0]    r_req;
    logic [LW-1:0] r_a;
    logic [LW-1:0] r_b;

    // stores
    logic [LW-1:0]     r_square [pfc_pkg::Cells];
    logic [2*CW-1:0]   r_pos    [pfc_pkg::Alpha];
    logic [pfc_pkg::Alpha-1:0] r_seen;

    logic [IW-1:0] r_fill_idx;
    logic [CW-1:0] r_fill_row;
    logic [CW-1:0] r_fill_col;
    logic [LW-1:0] r_fill_letter;
    logic          r_ready;

    logic [2*CW-1:0] r_pos_a_q;
    logic [2*CW-1:0] r_pos_b_q;
    logic [LW-1:0]   r_cell_a_q;
    logic [LW-1:0]   r_cell_b_q;

    logic          r_out_valid;
    logic [LW-1:0] r_out_a;
    logic [LW-1:0] r_out_b;
    logic          r_out_status;

    function automatic logic [LW-1:0] norm_letter(input logic [LW-1:0] raw);
        logic [LW-1:0] v;
        v = (raw > pfc_pkg::LETTER_Z) ? pfc_pkg::LETTER_Z : raw;
        if (v == pfc_pkg::LETTER_J) begin
            v = pfc_pkg::LETTER_I;
        end
        return v;
    endfunction

    function automatic logic [CW-1:0] coord_step(input logic [CW-1:0] x, input logic back);
        logic [CW-1:0] y;
        if (back) begin
            y = (x == '0) ? pfc_pkg::COORD_LAST : x - CW'(1);
        end else begin
            y = (x == pfc_pkg::COORD_LAST) ? '0 : x + CW'(1);
        end
        return y;
    endfunction

    function automatic logic [IW-1:0] cell_index(input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        return IW'({row, 2'b00}) + IW'(row) + IW'(col);
    endfunction

    // placement
    logic          place_req;
    logic [LW-1:0] place_letter;
    logic          place_en;
    logic          full;

    assign full         = (r_fill_idx == pfc_pkg::CELLS_FULL);
    assign place_req    = i_cmd.place_key | i_cmd.fill_step;
    assign place_letter = i_cmd.fill_step ? r_fill_letter : r_a;
    assign place_en     = place_req && !r_seen[place_letter] && !full
                          && (place_letter != pfc_pkg::LETTER_J);

    // pair lookup: new coordinates
    logic [CW-1:0] ra, ca, rb, cb;
    logic [CW-1:0] nra, nca, nrb, ncb;
    logic          back;

    assign {ra, ca} = r_pos_a_q;
    assign {rb, cb} = r_pos_b_q;
    assign back     = (r_req == pfc_pkg::REQ_DECRYPT);

    always_comb begin
        if (ra == rb) begin
            nra = ra;
            nrb = rb;
            nca = coord_step(ca, back);
            ncb = coord_step(cb, back);
        end else if (ca == cb) begin
            nra = coord_step(ra, back);
            nrb = coord_step(rb, back);
            nca = ca;
            ncb = cb;
        end else begin
            nra = ra;
            nrb = rb;
            nca = cb;
            ncb = ca;
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= '0;
            r_fill_idx    <= '0;
            r_fill_row    <= '0;
            r_fill_col    <= '0;
            r_fill_letter <= pfc_pkg::LETTER_A;
            r_ready       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (place_en) begin
                r_seen[place_letter] <= 1'b1;
                r_fill_idx           <= r_fill_idx + IW'(1);
                if (r_fill_col == pfc_pkg::COORD_LAST) begin
                    r_fill_col <= '0;
                    r_fill_row <= r_fill_row + CW'(1);
                end else begin
                    r_fill_col <= r_fill_col + CW'(1);
                end
            end
            if (i_cmd.fill_clear) begin
                r_fill_letter <= pfc_pkg::LETTER_A;
            end else if (i_cmd.fill_step) begin
                r_fill_letter <= r_fill_letter + LW'(1);
                if (r_fill_letter == pfc_pkg::LETTER_Z) begin
                    r_ready <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type;
            r_a   <= norm_letter(i_letter_a);
            r_b   <= norm_letter(i_letter_b);
        end
        if (i_cmd.out_load) begin
            r_out_a      <= r_ready ? r_cell_a_q : '0;
            r_out_b      <= r_ready ? r_cell_b_q : '0;
            r_out_status <= !r_ready;
        end
    end

    // position memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            r_pos[place_letter] <= {r_fill_row, r_fill_col};
        end
        if (i_cmd.pos_read) begin
            r_pos_a_q <= r_pos[r_a];
            r_pos_b_q <= r_pos[r_b];
        end
    end

    // square memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            r_square[r_fill_idx] <= place_letter;
        end
        if (i_cmd.cell_read) begin
            r_cell_a_q <= r_square[cell_index(nra, nca)];
            r_cell_b_q <= r_square[cell_index(nrb, ncb)];
        end
    end

    assign o_status_bus.square_ready = r_ready;
    assign o_status_bus.fill_last    = (r_fill_letter == pfc_pkg::LETTER_Z);
    assign o_status_bus.out_free     = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_status    = r_out_status;

endmodule

// File: hdl/pfc_ctrl.sv
// Controller: one-hot request sequencer that drives the datapath commands.
module pfc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_req_type,
    output logic                o_in_stall,
    input  pfc_pkg::t_dp_status i_status_bus,
    output pfc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_KEY  = 6'b000010,
        S_FILL = 6'b000100,
        S_POS  = 6'b001000,
        S_CELL = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    case (i_req_type)
                        pfc_pkg::REQ_KEY: begin
                            if (!i_status_bus.square_ready) n_state = S_KEY;
                        end
                        pfc_pkg::REQ_FINISH: begin
                            o_cmd.fill_clear = 1'b1;
                            if (!i_status_bus.square_ready) n_state = S_FILL;
                        end
                        default: begin
                            n_state = i_status_bus.square_ready ? S_POS : S_OUT;
                        end
                    endcase
                end
            end
            S_KEY: begin
                o_cmd.place_key = 1'b1;
                n_state         = S_IDLE;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status_bus.fill_last) n_state = S_IDLE;
            end
            S_POS: begin
                o_cmd.pos_read = 1'b1;
                n_state        = S_CELL;
            end
            S_CELL: begin
                o_cmd.cell_read = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (i_status_bus.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: dv/playfair_digraph_cipher_tb.sv
// Self-checking testbench for the Playfair 5x5 digraph cipher: key setup, finish, pair traffic.
module playfair_digraph_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Nothing accepted on either channel for this many cycles ends the run.
    // The longest legal quiet stretch is the forced output hold-off.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_PAIRS = 1620;
    localparam int unsigned QUIET_TAIL_AT = 1480;

    typedef struct packed {
        logic [4:0] out_a;
        logic [4:0] out_b;
        logic       status;
    } t_digraph;

    // Tracks the key square and holds the digraphs still owed by the block.
    class key_square_model;
        bit [4:0]    cells[pfc_pkg::Cells];
        bit [4:0]    where_is[pfc_pkg::Alpha];
        bit          seen[pfc_pkg::Alpha];
        int unsigned fill_idx;
        bit          ready;
        t_digraph    expected_digraphs[$];
        int unsigned errors;

        // Letters above Z read as Z, J reads as I.
        function bit [4:0] fold_letter(logic [4:0] raw);
            bit [4:0] v;
            v = raw;
            if (v > pfc_pkg::LETTER_Z) v = pfc_pkg::LETTER_Z;
            if (v == pfc_pkg::LETTER_J) v = pfc_pkg::LETTER_I;
            return v;
        endfunction

        function void place_letter(bit [4:0] v);
            if (seen[v] || fill_idx >= pfc_pkg::Cells) return;
            cells[fill_idx] = v;
            where_is[v] = 5'(fill_idx);
            seen[v] = 1'b1;
            fill_idx++;
        endfunction

        function void log_request(pfc_pkg::t_req req, logic [4:0] raw_a, logic [4:0] raw_b);
            bit [4:0] a;
            bit [4:0] b;
            int       pa, pb, ra, ca, rb, cb, step, na, nb;
            t_digraph want;
            a = fold_letter(raw_a);
            b = fold_letter(raw_b);
            case (req)
                pfc_pkg::REQ_KEY: begin
                    if (!ready) place_letter(a);
                end
                pfc_pkg::REQ_FINISH: begin
                    if (!ready) begin
                        for (int l = 0; l < pfc_pkg::Alpha; l++) begin
                            if (l != pfc_pkg::LETTER_J) place_letter(5'(l));
                        end
                        ready = 1'b1;
                    end
                end
                default: begin
                    if (!ready) begin
                        want.out_a  = '0;
                        want.out_b  = '0;
                        want.status = 1'b1;
                    end else begin
                        pa = where_is[a];
                        pb = where_is[b];
                        ra = pa / pfc_pkg::Side;
                        ca = pa % pfc_pkg::Side;
                        rb = pb / pfc_pkg::Side;
                        cb = pb % pfc_pkg::Side;
                        // one step back is Side-1 steps forward
                        step = (req == pfc_pkg::REQ_ENCRYPT) ? 1 : pfc_pkg::Side - 1;
                        if (ra == rb) begin
                            na = ra * pfc_pkg::Side + (ca + step) % pfc_pkg::Side;
                            nb = rb * pfc_pkg::Side + (cb + step) % pfc_pkg::Side;
                        end else if (ca == cb) begin
                            na = ((ra + step) % pfc_pkg::Side) * pfc_pkg::Side + ca;
                            nb = ((rb + step) % pfc_pkg::Side) * pfc_pkg::Side + cb;
                        end else begin
                            na = ra * pfc_pkg::Side + cb;
                            nb = rb * pfc_pkg::Side + ca;
                        end
                        want.out_a  = cells[na];
                        want.out_b  = cells[nb];
                        want.status = 1'b0;
                    end
                    expected_digraphs.insert(expected_digraphs.size(), want);
                end
            endcase
        endfunction

        function void check_digraph(logic [4:0] a, logic [4:0] b, logic st);
            t_digraph want;
            if (expected_digraphs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: a=%0d b=%0d status=%0d", a, b, st);
                return;
            end
            want = expected_digraphs.pop_front();
            if (want.out_a !== a || want.out_b !== b || want.status !== st) begin
                errors++;
                if (errors <= 10)
                    $display({"digraph mismatch: expected a=%0d b=%0d status=%0d,",
                              " got a=%0d b=%0d status=%0d"},
                             want.out_a, want.out_b, want.status, a, b, st);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_req_type;
    logic [4:0] i_letter_a;
    logic [4:0] i_letter_b;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [4:0] o_out_a;
    logic [4:0] o_out_b;
    logic       o_status;

    key_square_model board;
    bit              quiet_tail;     // last stretch: no idling on either side
    bit              hold_off_req;   // asks the receiver for one long hold-off
    int unsigned     gap_pct;        // sender idling odds, percent per request

    playfair_digraph_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_letter_a  (i_letter_a),
        .i_letter_b  (i_letter_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_a     (o_out_a),
        .o_out_b     (o_out_b),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    // Valid stays high between back-to-back requests.
    task automatic send_request(pfc_pkg::t_req req, logic [4:0] a, logic [4:0] b);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_letter_a <= a;
        i_letter_b <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.log_request(req, a, b);
    endtask

    // Sometimes swap I for J and Z for an out-of-range code: same letter to the block.
    function automatic logic [4:0] disguise(logic [4:0] v);
        if (v == pfc_pkg::LETTER_I && $urandom_range(0, 1)) return pfc_pkg::LETTER_J;
        if (v == pfc_pkg::LETTER_Z && $urandom_range(0, 1)) return 5'($urandom_range(26, 31));
        return v;
    endfunction

    function automatic logic [4:0] cell_at(int r, int c);
        return board.cells[r * pfc_pkg::Side + c];
    endfunction

    // Rectangles dominate uniform picks, so rows, columns and doubles are drawn on purpose.
    function automatic void draw_pair(output logic [4:0] a, output logic [4:0] b);
        int r, c1, c2;
        r  = $urandom_range(0, pfc_pkg::Side - 1);
        c1 = $urandom_range(0, pfc_pkg::Side - 1);
        c2 = $urandom_range(0, pfc_pkg::Side - 1);
        case ($urandom_range(0, 4))
            0, 1: begin
                a = 5'($urandom_range(0, 31));
                b = 5'($urandom_range(0, 31));
            end
            2: begin
                a = disguise(cell_at(r, c1));
                b = disguise(cell_at(r, c2));
            end
            3: begin
                a = disguise(cell_at(c1, r));
                b = disguise(cell_at(c2, r));
            end
            default: begin
                a = disguise(cell_at(r, c1));
                b = disguise(cell_at(r, c1));
            end
        endcase
    endfunction

    // Result side: check every accepted result; watchdog runs beside it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            board.check_digraph(o_out_a, o_out_b, o_status);
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stall bursts under changing stall odds, and one long
    // hold-off on request so the block backs up into its input.
    initial begin
        int unsigned tick;
        int unsigned stall_pct;
        tick = 0;
        stall_pct = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 200 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && i_rst_n && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Sender: directed key setup and pair checks, then random pair traffic.
    initial begin
        int unsigned   order[pfc_pkg::Alpha];
        int unsigned   j, tmp, n_keys, pairs_sent, loop_cnt;
        logic [4:0]    a, b;
        pfc_pkg::t_req req;

        board = new();
        gap_pct = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= pfc_pkg::REQ_KEY;
        i_letter_a <= '0;
        i_letter_b <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pairs before the square is finished: status set, letters zero
        send_request(pfc_pkg::REQ_ENCRYPT, pfc_pkg::LETTER_A, pfc_pkg::LETTER_Z);
        send_request(pfc_pkg::REQ_DECRYPT, 5'd31, pfc_pkg::LETTER_J);
        // J folds to I, so the I that follows is a repeat; 31 and 27 both read as Z
        send_request(pfc_pkg::REQ_KEY, pfc_pkg::LETTER_J, pfc_pkg::LETTER_A);
        send_request(pfc_pkg::REQ_KEY, pfc_pkg::LETTER_I, 5'd31);
        send_request(pfc_pkg::REQ_KEY, 5'd31, pfc_pkg::LETTER_A);
        send_request(pfc_pkg::REQ_KEY, 5'd27, 5'd17);
        send_request(pfc_pkg::REQ_KEY, pfc_pkg::LETTER_A, 5'd0);

        gap_pct = 20;
        // Either fill the square from key letters alone (then extra keys find it
        // full), or give a short key and leave the rest to the finish pass.
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < pfc_pkg::Alpha; i++) order[i] = i;
            for (int i = pfc_pkg::Alpha - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < pfc_pkg::Alpha; i++)
                send_request(pfc_pkg::REQ_KEY, disguise(5'(order[i])),
                             5'($urandom_range(0, 31)));
            repeat (3)
                send_request(pfc_pkg::REQ_KEY, 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)));
        end else begin
            n_keys = $urandom_range(3, 20);
            repeat (n_keys)
                send_request(pfc_pkg::REQ_KEY, 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)));
        end

        send_request(pfc_pkg::REQ_FINISH, 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)));
        // repeated finish and late key letter: both ignored
        send_request(pfc_pkg::REQ_FINISH, pfc_pkg::LETTER_A, pfc_pkg::LETTER_A);
        send_request(pfc_pkg::REQ_KEY, 5'($urandom_range(0, 31)), pfc_pkg::LETTER_Z);

        // Row and column cases straddle the wrap edge.
        for (int k = 0; k < 2; k++) begin
            req = (k == 0) ? pfc_pkg::REQ_ENCRYPT : pfc_pkg::REQ_DECRYPT;
            send_request(req, cell_at($urandom_range(0, 4), 0), cell_at(0, 4));
            send_request(req, cell_at(1, 0), cell_at(1, 4));
            send_request(req, cell_at(0, 3), cell_at(4, 3));
            send_request(req, cell_at(1, 0), cell_at(3, 4));
            send_request(req, cell_at(2, 2), cell_at(2, 2));
            send_request(req, pfc_pkg::LETTER_J, cell_at(0, 0));
            send_request(req, 5'd28, pfc_pkg::LETTER_A);
        end

        hold_off_req = 1'b1;
        pairs_sent = 0;
        loop_cnt = 0;
        while (pairs_sent < RANDOM_PAIRS) begin
            if (loop_cnt % 128 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            loop_cnt++;
            if (pairs_sent >= QUIET_TAIL_AT) quiet_tail = 1'b1;
            if ($urandom_range(0, 19) == 0) begin
                // ignored noise now that the square is fixed
                req = $urandom_range(0, 1) ? pfc_pkg::REQ_KEY : pfc_pkg::REQ_FINISH;
                send_request(req, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end else begin
                draw_pair(a, b);
                req = $urandom_range(0, 1) ? pfc_pkg::REQ_ENCRYPT : pfc_pkg::REQ_DECRYPT;
                send_request(req, a, b);
                pairs_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (board.expected_digraphs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hdl/pfc_pkg.sv
hdl/pfc_datapath.sv
hdl/pfc_ctrl.sv
hdl/playfair_digraph_cipher.sv
dv/playfair_digraph_cipher_tb.sv
